[sv/rrbs_pkg.sv]
// package for the repeat bound scanner: widths, character codes, classified item, phase and action codes
// no dependencies
`default_nettype none

package rrbs_pkg;

  localparam int NUMBER_WIDTH = 31;
  localparam int LIMIT_WIDTH  = 31;
  localparam int SUM_WIDTH    = NUMBER_WIDTH + 4;
  localparam int CMP_WIDTH    = (NUMBER_WIDTH > LIMIT_WIDTH) ? NUMBER_WIDTH : LIMIT_WIDTH;
  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = LIMIT_WIDTH'(50);
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [7:0] CHAR_LBRACE = 8'h7b;
  localparam logic [7:0] CHAR_RBRACE = 8'h7d;
  localparam logic [7:0] CHAR_COMMA  = 8'h2c;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_LF     = 8'h0a;
  localparam logic [7:0] CHAR_FF     = 8'h0c;
  localparam logic [7:0] CHAR_CR     = 8'h0d;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;

  // classified item handed from front to back
  typedef struct packed {
    logic       lbrace;
    logic       rbrace;
    logic       comma;
    logic       space;
    logic       digit;
    logic [3:0] digit_val;
    logic       last;
    logic       no_char;
  } item_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_OPEN,
    PH_NUM1,
    PH_NUM1WS,
    PH_COMMA,
    PH_NUM2,
    PH_NUM2WS
  } phase_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_FAIL,
    ACT_START,
    ACT_ADD,
    ACT_MARK,
    ACT_CLOSE_NUM1,
    ACT_CLOSE_FB,
    ACT_CLOSE_NUM2
  } act_e;

endpackage

`default_nettype wire

[sv/rrbs_in_if.sv]
// input channel of the repeat bound scanner: valid/ready plus one pattern byte
// no dependencies
`default_nettype none

interface rrbs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;
  logic       no_char;

  modport source (output valid, output char_code, output last, output no_char, input ready);
  modport sink   (input valid, input char_code, input last, input no_char, output ready);
endinterface

`default_nettype wire

[sv/rrbs_out_if.sv]
// result channel of the repeat bound scanner: valid/ready plus the slow flag
// no dependencies
`default_nettype none

interface rrbs_out_if;
  logic valid;
  logic ready;
  logic slow;

  modport source (output valid, output slow, input ready);
  modport sink   (input valid, input slow, output ready);
endinterface

`default_nettype wire

[sv/regex_repeat_bound_scanner_unit.sv]
// top level of the regex repeat bound scanner
// depends on rrbs_pkg, rrbs_in_if, rrbs_out_if, rrbs_front, rrbs_queue, rrbs_back
`default_nettype none

// The scanner takes a regular-expression text one byte per item and flags it
// slow when a complete {n}, {n,} or {n,m} quantifier (whitespace allowed around
// numbers and comma) carries a count above repeat_limit; counts too large for
// NUMBER_WIDTH bits are ignored. One result item comes out for each input item
// marked last, carrying the sticky flag; the scan then starts over. An item with
// no_char set carries no byte, so a lone last item with no_char reports 0.
// Throughput is one item per clock unless the back stalls on a held result:
// the front classifies the byte as it is accepted and writes it into a
// two-entry queue, the back matcher takes one queued item a cycle and registers
// the result (its multiply-by-ten accumulator is a single add). repeat_limit
// resets to 50 and may only be written while no item is in flight.

module regex_repeat_bound_scanner_unit import rrbs_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  rrbs_in_if.sink                     in_i,
  rrbs_out_if.source                  out_o,
  input  wire logic                   cfg_we_i,
  input  wire logic [LIMIT_WIDTH-1:0] cfg_wdata_i
);

  // repeat limit register
  logic [LIMIT_WIDTH-1:0] limit_q;

  // front to queue
  item_t front_item;
  logic  queue_full;

  // queue to back
  logic  queue_valid;
  item_t queue_item;
  logic  back_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // input side waits only on queue space, which runs out when the back stalls on the result side
  assign in_i.ready = !queue_full;

  rrbs_front u_front (
    .char_code_i (in_i.char_code),
    .last_i      (in_i.last),
    .no_char_i   (in_i.no_char),
    .item_o      (front_item)
  );

  rrbs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_i.valid),
    .push_item_i (front_item),
    .full_o      (queue_full),
    .pop_i       (back_pop),
    .valid_o     (queue_valid),
    .item_o      (queue_item)
  );

  // back stalls only on a last item while the result register is still held
  rrbs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .limit_i      (limit_q),
    .item_valid_i (queue_valid),
    .item_i       (queue_item),
    .pop_o        (back_pop),
    .out_valid_o  (out_o.valid),
    .out_slow_o   (out_o.slow),
    .out_ready_i  (out_o.ready)
  );

endmodule

`default_nettype wire

[sv/rrbs_front.sv]
// front end: classifies each accepted byte into an item_t for the queue
// depends on rrbs_pkg
`default_nettype none

module rrbs_front import rrbs_pkg::*; (
  input  wire logic [7:0] char_code_i,
  input  wire logic       last_i,
  input  wire logic       no_char_i,
  output item_t           item_o
);

  always_comb begin
    item_o.lbrace    = (char_code_i == CHAR_LBRACE);
    item_o.rbrace    = (char_code_i == CHAR_RBRACE);
    item_o.comma     = (char_code_i == CHAR_COMMA);
    item_o.space     = (char_code_i == CHAR_TAB) || (char_code_i == CHAR_LF) ||
                       (char_code_i == CHAR_FF)  || (char_code_i == CHAR_CR) ||
                       (char_code_i == CHAR_SPACE);
    item_o.digit     = (char_code_i >= CHAR_ZERO) && (char_code_i <= CHAR_NINE);
    // low nibble of an ascii digit is its value
    item_o.digit_val = char_code_i[3:0];
    item_o.last      = last_i;
    item_o.no_char   = no_char_i;
  end

endmodule

`default_nettype wire

[sv/rrbs_queue.sv]
// two-entry queue of classified items between front and back
// depends on rrbs_pkg
`default_nettype none

module rrbs_queue import rrbs_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  item_t      push_item_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       valid_o,
  output item_t      item_o
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  item_t              mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

[sv/rrbs_back.sv]
// back end: quantifier matcher, decimal accumulator, sticky flag and result register
// depends on rrbs_pkg
`default_nettype none

module rrbs_back import rrbs_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [LIMIT_WIDTH-1:0] limit_i,
  input  wire logic                   item_valid_i,
  input  item_t                       item_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  output logic                        out_slow_o,
  input  wire logic                   out_ready_i
);

  phase_e                  phase_q, phase_d;
  act_e                    act;
  logic [NUMBER_WIDTH-1:0] num_q, num_d;
  logic                    ovf_q, ovf_d;
  logic                    fb_q, fb_d;
  logic                    slow_q, slow_d;
  logic                    out_valid_q, out_valid_d;
  logic                    out_slow_q, out_slow_d;
  logic [SUM_WIDTH-1:0]    sum;
  logic                    sum_ovf;
  logic                    big;
  logic                    ch;

  assign pop_o       = item_valid_i && (!item_i.last || !out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_slow_o  = out_slow_q;
  assign ch          = pop_o && !item_i.no_char;

  // num * 10 + digit, overflow when anything lands above the number range
  assign sum     = (SUM_WIDTH'(num_q) << 3) + (SUM_WIDTH'(num_q) << 1) +
                   SUM_WIDTH'(item_i.digit_val);
  assign sum_ovf = |sum[SUM_WIDTH-1:NUMBER_WIDTH];
  assign big     = !ovf_q && (CMP_WIDTH'(num_q) > CMP_WIDTH'(limit_i));

  // next phase and action
  always_comb begin
    phase_d = phase_q;
    act     = ACT_NONE;
    if (ch) begin
      act = ACT_FAIL;
      case (phase_q)
        PH_OPEN: begin
          if (item_i.space) begin
            act = ACT_NONE;
          end else if (item_i.digit) begin
            act = ACT_START; phase_d = PH_NUM1;
          end
        end
        PH_NUM1: begin
          if (item_i.digit) begin
            act = ACT_ADD;
          end else if (item_i.space) begin
            act = ACT_MARK; phase_d = PH_NUM1WS;
          end else if (item_i.comma) begin
            act = ACT_MARK; phase_d = PH_COMMA;
          end else if (item_i.rbrace) begin
            act = ACT_CLOSE_NUM1;
          end
        end
        PH_NUM1WS: begin
          if (item_i.space) begin
            act = ACT_NONE;
          end else if (item_i.comma) begin
            act = ACT_NONE; phase_d = PH_COMMA;
          end else if (item_i.rbrace) begin
            act = ACT_CLOSE_FB;
          end
        end
        PH_COMMA: begin
          if (item_i.space) begin
            act = ACT_NONE;
          end else if (item_i.rbrace) begin
            act = ACT_CLOSE_FB;
          end else if (item_i.digit) begin
            act = ACT_START; phase_d = PH_NUM2;
          end
        end
        PH_NUM2: begin
          if (item_i.digit) begin
            act = ACT_ADD;
          end else if (item_i.space) begin
            act = ACT_NONE; phase_d = PH_NUM2WS;
          end else if (item_i.rbrace) begin
            act = ACT_CLOSE_NUM2;
          end
        end
        PH_NUM2WS: begin
          if (item_i.space) begin
            act = ACT_NONE;
          end else if (item_i.rbrace) begin
            act = ACT_CLOSE_NUM2;
          end
        end
        default: begin
          act = ACT_FAIL;
        end
      endcase
      if (act == ACT_FAIL) begin
        phase_d = item_i.lbrace ? PH_OPEN : PH_IDLE;
      end else if ((act == ACT_CLOSE_NUM1) || (act == ACT_CLOSE_FB) ||
                   (act == ACT_CLOSE_NUM2)) begin
        phase_d = PH_IDLE;
      end
    end
    if (pop_o && item_i.last) begin
      phase_d = PH_IDLE;
    end
  end

  // datapath and result
  always_comb begin
    num_d       = num_q;
    ovf_d       = ovf_q;
    fb_d        = fb_q;
    slow_d      = slow_q;
    case (act)
      ACT_FAIL: begin
        num_d = '0; ovf_d = 1'b0; fb_d = 1'b0;
      end
      ACT_START: begin
        num_d = NUMBER_WIDTH'(item_i.digit_val); ovf_d = 1'b0;
      end
      ACT_ADD: begin
        if (!ovf_q) begin
          if (sum_ovf) begin
            ovf_d = 1'b1;
          end else begin
            num_d = sum[NUMBER_WIDTH-1:0];
          end
        end
      end
      ACT_MARK: begin
        fb_d = big;
      end
      ACT_CLOSE_NUM1: begin
        slow_d = slow_q || big;
        num_d = '0; ovf_d = 1'b0; fb_d = 1'b0;
      end
      ACT_CLOSE_FB: begin
        slow_d = slow_q || fb_q;
        num_d = '0; ovf_d = 1'b0; fb_d = 1'b0;
      end
      ACT_CLOSE_NUM2: begin
        slow_d = slow_q || fb_q || big;
        num_d = '0; ovf_d = 1'b0; fb_d = 1'b0;
      end
      default: begin
      end
    endcase

    out_valid_d = out_valid_q && !out_ready_i;
    out_slow_d  = out_slow_q;
    if (pop_o && item_i.last) begin
      out_valid_d = 1'b1;
      out_slow_d  = slow_d;
      num_d       = '0;
      ovf_d       = 1'b0;
      fb_d        = 1'b0;
      slow_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      num_q       <= '0;
      ovf_q       <= 1'b0;
      fb_q        <= 1'b0;
      slow_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      num_q       <= num_d;
      ovf_q       <= ovf_d;
      fb_q        <= fb_d;
      slow_q      <= slow_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_slow_q <= out_slow_d;
  end

endmodule

`default_nettype wire
